/* src/vgts_pkg.sv */
// ----------------------------------------------------------------------------
// Voxel grid sampler package
// Shared widths, operation codes, register indexes and the RAM write port struct.
// ----------------------------------------------------------------------------
package vgts_pkg;

    localparam int ADDR_W  = 15;
    localparam int VAL_W   = 16;
    localparam int FRAC_W  = 16;
    localparam int FIX_W   = 32;
    localparam int PADDR_W = 5;
    localparam int REG_W   = 3;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [REG_W-1:0] {
        REG_BOX_MIN_X,
        REG_BOX_MIN_Y,
        REG_BOX_MIN_Z,
        REG_VPU_X,
        REG_VPU_Y,
        REG_VPU_Z
    } reg_idx_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
    } ram_wr_t;

endpackage

/* src/vgts_voxel_ram.sv */
// ----------------------------------------------------------------------------
// Voxel memory copy
// One write port and one registered read port over the whole voxel store.
// ----------------------------------------------------------------------------
module vgts_voxel_ram
    import vgts_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  ram_wr_t           wr,
    input  logic [ADDR_W-1:0] raddr,
    output logic [VAL_W-1:0]  rdata
);

    logic [VAL_W-1:0] mem [2**ADDR_W];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.waddr] <= wr.wdata;
        end
        if (en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/vgts_axis_map.sv */
// ----------------------------------------------------------------------------
// Axis mapper
// Three stages: offset from the box corner, scaling to voxel space, and the
// inside test with half-voxel shift, fraction split and edge clamping.
// ----------------------------------------------------------------------------
module vgts_axis_map
    import vgts_pkg::*;
#(
    parameter int GRID = 32
)
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [FIX_W-1:0]   point,
    input  logic signed [FIX_W-1:0]   bmin,
    input  logic [FIX_W-1:0]          vpu,
    output logic [$clog2(GRID)-1:0]   c0,
    output logic [$clog2(GRID)-1:0]   c1,
    output logic [FRAC_W-1:0]         frac,
    output logic                      in_box
);

    localparam int CW = $clog2(GRID);
    localparam logic [47:0] VMAX = 48'(GRID) << 16;
    localparam logic [8:0]  GMAX = 9'(GRID - 1);

    logic signed [FIX_W:0] d_reg;
    logic [47:0]           v_reg;
    logic                  ok_reg;
    logic [CW-1:0]         c0_reg;
    logic [CW-1:0]         c1_reg;
    logic [FRAC_W-1:0]     frac_reg;
    logic                  inside_reg;

    logic [63:0] prod;
    logic [47:0] u;
    logic [8:0]  uhi;
    logic [8:0]  cell_lo;
    logic [8:0]  c0_next;
    logic [8:0]  c1_next;

    always_comb
    begin
        prod    = 64'(d_reg[FIX_W-1:0]) * 64'(vpu);
        u       = v_reg + 48'h8000;
        uhi     = u[24:16];
        cell_lo = uhi - 9'd1;
        if (uhi == 9'd0)
        begin
            c0_next = 9'd0;
        end
        else if (cell_lo > GMAX)
        begin
            c0_next = GMAX;
        end
        else
        begin
            c0_next = cell_lo;
        end
        c1_next = (uhi > GMAX) ? GMAX : uhi;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg      <= (FIX_W+1)'(point) - (FIX_W+1)'(bmin);
            v_reg      <= prod[63:16];
            ok_reg     <= (vpu == '0) || !d_reg[FIX_W];
            c0_reg     <= c0_next[CW-1:0];
            c1_reg     <= c1_next[CW-1:0];
            frac_reg   <= u[FRAC_W-1:0];
            inside_reg <= ok_reg && (v_reg <= VMAX);
        end
    end

    assign c0     = c0_reg;
    assign c1     = c1_reg;
    assign frac   = frac_reg;
    assign in_box = inside_reg;

endmodule

/* src/vgts_lerp.sv */
// ----------------------------------------------------------------------------
// Linear blend stage
// Registers a * (1 - f) + b * f with a Q0.16 weight, kept exact.
// ----------------------------------------------------------------------------
module vgts_lerp
    import vgts_pkg::*;
#(
    parameter int DW = 16
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [DW-1:0]     a,
    input  logic [DW-1:0]     b,
    input  logic [FRAC_W-1:0] f,
    output logic [DW+15:0]    q
);

    logic [FRAC_W:0]  w0;
    logic [DW+16:0]   pa;
    logic [DW+16:0]   pb;
    logic [DW+16:0]   sum;
    logic [DW+15:0]   q_reg;

    always_comb
    begin
        w0  = 17'h10000 - {1'b0, f};
        pa  = (DW+17)'(a) * (DW+17)'(w0);
        pb  = (DW+17)'(b) * (DW+17)'(f);
        sum = pa + pb;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= sum[DW+15:0];
        end
    end

    assign q = q_reg;

endmodule

/* src/voxel_grid_trilinear_sampler.sv */
// ----------------------------------------------------------------------------
// Voxel grid trilinear sampler
// Voxel store with one-per-cycle density sampling by trilinear blending, unless the output stalls.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless the output stalls,
// voxel writes and sample points alike, and returns a result for each sample
// point, in order. Three stages map the point to voxel space, one forms the
// eight corner addresses, one reads eight copies of the voxel store in parallel
// (every write goes to all copies), and three blend along x, y and z. The whole
// pipeline stalls together only while a finished result waits on the output.
module voxel_grid_trilinear_sampler
    import vgts_pkg::*;
#(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic [ADDR_W-1:0]        voxel_index,
    input  logic [VAL_W-1:0]         voxel_value,
    input  logic signed [FIX_W-1:0]  point_x,
    input  logic signed [FIX_W-1:0]  point_y,
    input  logic signed [FIX_W-1:0]  point_z,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [VAL_W-1:0]         density,
    output logic                     inside_res,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [FIX_W-1:0]         pwdata,
    output logic [FIX_W-1:0]         prdata,
    output logic                     pready
);

    localparam int XW = $clog2(GRID_X);
    localparam int YW = $clog2(GRID_Y);
    localparam int ZW = $clog2(GRID_Z);
    localparam logic [31:0] STRIDE_Y = 32'(GRID_X);
    localparam logic [31:0] STRIDE_Z = 32'(GRID_X * GRID_Y);

    logic [FIX_W-1:0] bmin_reg [3];
    logic [FIX_W-1:0] vpu_reg  [3];

    logic              en;
    logic [8:1]        vld_reg;
    logic [4:1]        op_reg;
    logic [ADDR_W-1:0] idx_reg [4:1];
    logic [VAL_W-1:0]  val_reg [4:1];
    logic [8:4]        in_reg;
    logic [FRAC_W-1:0] fx_reg [5:4];
    logic [FRAC_W-1:0] fy_reg [6:4];
    logic [FRAC_W-1:0] fz_reg [7:4];
    logic [ADDR_W-1:0] addr_reg [8];

    logic [XW-1:0]     x0, x1;
    logic [YW-1:0]     y0, y1;
    logic [ZW-1:0]     z0, z1;
    logic [FRAC_W-1:0] fx, fy, fz;
    logic              ix, iy, iz;
    logic [ADDR_W-1:0] addr_next [8];
    logic [31:0]       lin [8];
    ram_wr_t           ram_wr;
    logic [VAL_W-1:0]  rd [8];
    logic [31:0]       cx [4];
    logic [47:0]       cy [2];
    logic [63:0]       acc;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign en       = !vld_reg[8] || out_ready;
    assign in_ready = en;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign cfg_idx  = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bmin_reg[0] <= '0;
            bmin_reg[1] <= '0;
            bmin_reg[2] <= '0;
            vpu_reg[0]  <= 32'd2097152;
            vpu_reg[1]  <= 32'd2097152;
            vpu_reg[2]  <= 32'd2097152;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_BOX_MIN_X: bmin_reg[0] <= pwdata;
                REG_BOX_MIN_Y: bmin_reg[1] <= pwdata;
                REG_BOX_MIN_Z: bmin_reg[2] <= pwdata;
                REG_VPU_X:     vpu_reg[0]  <= pwdata;
                REG_VPU_Y:     vpu_reg[1]  <= pwdata;
                REG_VPU_Z:     vpu_reg[2]  <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_BOX_MIN_X: prdata = bmin_reg[0];
            REG_BOX_MIN_Y: prdata = bmin_reg[1];
            REG_BOX_MIN_Z: prdata = bmin_reg[2];
            REG_VPU_X:     prdata = vpu_reg[0];
            REG_VPU_Y:     prdata = vpu_reg[1];
            REG_VPU_Z:     prdata = vpu_reg[2];
            default:       prdata = '0;
        endcase
    end

    vgts_axis_map #(.GRID(GRID_X)) u_map_x (
        .clk(clk), .en(en), .point(point_x), .bmin(bmin_reg[0]), .vpu(vpu_reg[0]),
        .c0(x0), .c1(x1), .frac(fx), .in_box(ix)
    );

    vgts_axis_map #(.GRID(GRID_Y)) u_map_y (
        .clk(clk), .en(en), .point(point_y), .bmin(bmin_reg[1]), .vpu(vpu_reg[1]),
        .c0(y0), .c1(y1), .frac(fy), .in_box(iy)
    );

    vgts_axis_map #(.GRID(GRID_Z)) u_map_z (
        .clk(clk), .en(en), .point(point_z), .bmin(bmin_reg[2]), .vpu(vpu_reg[2]),
        .c0(z0), .c1(z1), .frac(fz), .in_box(iz)
    );

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            lin[k] = 32'(k[0] ? x1 : x0)
                   + 32'(k[1] ? y1 : y0) * STRIDE_Y
                   + 32'(k[2] ? z1 : z0) * STRIDE_Z;
            addr_next[k] = lin[k][ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            vld_reg[2] <= vld_reg[1];
            vld_reg[3] <= vld_reg[2];
            vld_reg[4] <= vld_reg[3];
            vld_reg[5] <= vld_reg[4] && (op_reg[4] == OP_SAMPLE);
            vld_reg[6] <= vld_reg[5];
            vld_reg[7] <= vld_reg[6];
            vld_reg[8] <= vld_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[1]  <= op;
            idx_reg[1] <= voxel_index;
            val_reg[1] <= voxel_value;
            for (int s = 2; s <= 4; s++)
            begin
                op_reg[s]  <= op_reg[s-1];
                idx_reg[s] <= idx_reg[s-1];
                val_reg[s] <= val_reg[s-1];
            end
            in_reg[4] <= ix && iy && iz;
            in_reg[5] <= in_reg[4];
            in_reg[6] <= in_reg[5];
            in_reg[7] <= in_reg[6];
            in_reg[8] <= in_reg[7];
            fx_reg[4] <= fx;
            fx_reg[5] <= fx_reg[4];
            fy_reg[4] <= fy;
            fy_reg[5] <= fy_reg[4];
            fy_reg[6] <= fy_reg[5];
            fz_reg[4] <= fz;
            fz_reg[5] <= fz_reg[4];
            fz_reg[6] <= fz_reg[5];
            fz_reg[7] <= fz_reg[6];
            addr_reg  <= addr_next;
        end
    end

    assign ram_wr.we    = en && vld_reg[4] && (op_reg[4] == OP_WRITE);
    assign ram_wr.waddr = idx_reg[4];
    assign ram_wr.wdata = val_reg[4];

    for (genvar k = 0; k < 8; k++)
    begin : g_ram
        vgts_voxel_ram u_ram (
            .clk(clk), .en(en), .wr(ram_wr), .raddr(addr_reg[k]), .rdata(rd[k])
        );
    end

    for (genvar j = 0; j < 4; j++)
    begin : g_lerp_x
        vgts_lerp #(.DW(16)) u_lerp (
            .clk(clk), .en(en), .a(rd[2*j]), .b(rd[2*j+1]), .f(fx_reg[5]), .q(cx[j])
        );
    end

    for (genvar j = 0; j < 2; j++)
    begin : g_lerp_y
        vgts_lerp #(.DW(32)) u_lerp (
            .clk(clk), .en(en), .a(cx[2*j]), .b(cx[2*j+1]), .f(fy_reg[6]), .q(cy[j])
        );
    end

    vgts_lerp #(.DW(48)) u_lerp_z (
        .clk(clk), .en(en), .a(cy[0]), .b(cy[1]), .f(fz_reg[7]), .q(acc)
    );

    assign out_valid  = vld_reg[8];
    assign inside_res = in_reg[8];
    assign density    = in_reg[8] ? (acc[63:48] + 16'(acc[47])) : '0;

endmodule
